// File: rtl/pvd_pkg.sv
// pvd_pkg: shared widths, constants and types of the peak vector displacement unit
// depends on nothing; imported by every module of the block
package pvd_pkg;

   // field widths
   localparam int POS_W   = 30;
   localparam int DIFF_W  = POS_W + 1;
   localparam int TERM_W  = 2 * POS_W;
   localparam int SQ_W    = TERM_W + 2;
   localparam int DISP_W  = SQ_W / 2;
   localparam int COUNT_W = 16;

   // default trace length bound and queue depth
   localparam int MAX_SAMPLES_DEF = 65536;
   localparam int QUEUE_DEPTH     = 4;

   // one classified item handed from front to back
   typedef struct packed {
      logic signed [DIFF_W-1:0] du;
      logic signed [DIFF_W-1:0] dn;
      logic signed [DIFF_W-1:0] de;
      logic                     measure;
      logic                     last;
   } work_type;

   // square root request and status
   typedef struct packed {
      logic            start;
      logic [SQ_W-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic              busy;
      logic [DISP_W-1:0] root;
   } sqrt_rsp_type;

   // back end sequencer
   typedef enum logic {
      ST_RUN,
      ST_ROOT
   } back_state_type;

endpackage

// File: rtl/pvd_front.sv
// pvd_front: accepts samples, captures the baseline and classifies each item
// depends on pvd_pkg; feeds pvd_queue
module pvd_front #(
   parameter int MAX_SAMPLES = pvd_pkg::MAX_SAMPLES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [pvd_pkg::COUNT_W-1:0]          csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [pvd_pkg::POS_W-1:0]     req_up_pos,
   input  logic signed [pvd_pkg::POS_W-1:0]     req_north_pos,
   input  logic signed [pvd_pkg::POS_W-1:0]     req_east_pos,
   input  logic                                 req_sample_valid,
   input  logic                                 req_sample_last,
   input  logic                                 q_full,
   output logic                                 push,
   output pvd_pkg::work_type                    push_data
);
   import pvd_pkg::*;

   localparam int CountSat = (MAX_SAMPLES - 1 < 65535) ? MAX_SAMPLES - 1 : 65535;

   logic [COUNT_W-1:0]      ref_ff, ref_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic                    taken_ff, taken_in;
   logic                    good_ff, good_in;
   logic signed [POS_W-1:0] bu_ff, bu_in, bn_ff, bn_in, be_ff, be_in;
   logic                    take;
   logic                    good_eff;
   logic signed [POS_W-1:0] bu_eff, bn_eff, be_eff;

   assign req_ready = !q_full;
   assign push      = req_valid && req_ready;

   // baseline capture and classification of the incoming item
   always_comb begin
      take     = !taken_ff && (count_ff == ref_ff || req_sample_last);
      bu_eff   = take ? req_up_pos    : bu_ff;
      bn_eff   = take ? req_north_pos : bn_ff;
      be_eff   = take ? req_east_pos  : be_ff;
      good_eff = take ? req_sample_valid : good_ff;

      push_data.du      = DIFF_W'(req_up_pos)    - DIFF_W'(bu_eff);
      push_data.dn      = DIFF_W'(req_north_pos) - DIFF_W'(bn_eff);
      push_data.de      = DIFF_W'(req_east_pos)  - DIFF_W'(be_eff);
      push_data.measure = (taken_ff || take) && good_eff && req_sample_valid;
      push_data.last    = req_sample_last;
   end

   // trace state update
   always_comb begin
      ref_in   = csr_write_en ? csr_write_data : ref_ff;
      count_in = count_ff;
      taken_in = taken_ff;
      good_in  = good_ff;
      bu_in    = bu_eff;
      bn_in    = bn_eff;
      be_in    = be_eff;
      if (push) begin
         if (req_sample_last) begin
            count_in = '0;
            taken_in = 1'b0;
            good_in  = 1'b0;
         end else begin
            taken_in = taken_ff || take;
            good_in  = good_eff;
            if (count_ff != COUNT_W'(CountSat))
               count_in = count_ff + 1'b1;
         end
      end else begin
         bu_in = bu_ff;
         bn_in = bn_ff;
         be_in = be_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff   <= '0;
         count_ff <= '0;
         taken_ff <= 1'b0;
         good_ff  <= 1'b0;
      end else begin
         ref_ff   <= ref_in;
         count_ff <= count_in;
         taken_ff <= taken_in;
         good_ff  <= good_in;
      end
   end

   // baseline values, only read once taken
   always_ff @(posedge clock) begin
      bu_ff <= bu_in;
      bn_ff <= bn_in;
      be_ff <= be_in;
   end

endmodule

// File: rtl/pvd_queue.sv
// pvd_queue: short first-in first-out queue of classified items
// depends on pvd_pkg; sits between pvd_front and pvd_back
module pvd_queue (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    push,
   input  pvd_pkg::work_type                       push_data,
   input  logic                                    pop,
   output pvd_pkg::work_type                       pop_data,
   output logic [$clog2(pvd_pkg::QUEUE_DEPTH+1)-1:0] count
);
   import pvd_pkg::*;

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   work_type          mem_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;

   assign count    = cnt_ff;
   assign pop_data = mem_ff[rd_ff];

   // pointer and occupancy update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push)
         wr_in = (wr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)
         rd_in = (rd_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop)
         cnt_in = cnt_ff + 1'b1;
      else if (pop && !push)
         cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ff] <= push_data;
   end

endmodule

// File: rtl/pvd_sqrt.sv
// pvd_sqrt: iterative floor square root, one result bit per cycle
// depends on pvd_pkg; used by pvd_back
module pvd_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  pvd_pkg::sqrt_req_type req,
   output pvd_pkg::sqrt_rsp_type rsp
);
   import pvd_pkg::*;

   localparam int RemW = DISP_W + 2;
   localparam int CntW = $clog2(DISP_W + 1);

   logic [SQ_W-1:0]   rad_ff, rad_in;
   logic [RemW-1:0]   rem_ff, rem_in;
   logic [DISP_W-1:0] root_ff, root_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [RemW+1:0]   rem_sh;
   logic [RemW+1:0]   trial;

   assign rsp.busy = busy_ff;
   assign rsp.root = root_ff;

   // bring down two bits, try to subtract the trial divisor
   always_comb begin
      rem_sh  = {rem_ff, rad_ff[SQ_W-1 -: 2]};
      trial   = (RemW+2)'({root_ff, 2'b01});
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (req.start) begin
         rad_in  = req.radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CntW'(DISP_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SQ_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = RemW'(rem_sh - trial);
            root_in = {root_ff[DISP_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[RemW-1:0];
            root_in = {root_ff[DISP_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CntW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

endmodule

// File: rtl/pvd_back.sv
// pvd_back: squares, running maximum and result register of the block
// depends on pvd_pkg and pvd_sqrt; drains pvd_queue
module pvd_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  pvd_pkg::work_type              q_data,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [pvd_pkg::DISP_W-1:0]     rsp_peak_disp,
   output logic                           rsp_peak_found
);
   import pvd_pkg::*;

   back_state_type              state_ff, state_in;
   logic                        a_vld_ff, a_vld_in;
   logic                        a_meas_ff, a_last_ff;
   logic [TERM_W-1:0]           su_ff, sn_ff, se_ff;
   logic signed [2*DIFF_W-1:0]  pu, pn, pe;
   logic [SQ_W-1:0]             max_ff, max_in, max_nx, sum;
   logic                        good_ff, good_in, good_nx;
   logic                        found_ff, found_in;
   logic                        out_vld_ff, out_vld_in;
   logic [DISP_W-1:0]           disp_ff, disp_in;
   logic                        ofound_ff, ofound_in;
   logic                        take_a;
   sqrt_req_type                sq_req;
   sqrt_rsp_type                sq_rsp;

   assign rsp_valid      = out_vld_ff;
   assign rsp_peak_disp  = disp_ff;
   assign rsp_peak_found = ofound_ff;

   // square stage loads whenever it is empty or handing on
   assign pop      = !q_empty && (state_ff == ST_RUN || !a_vld_ff);
   assign a_vld_in = pop || (a_vld_ff && !take_a);
   assign pu       = q_data.du * q_data.du;
   assign pn       = q_data.dn * q_data.dn;
   assign pe       = q_data.de * q_data.de;

   always_ff @(posedge clock) begin
      if (pop) begin
         su_ff     <= pu[TERM_W-1:0];
         sn_ff     <= pn[TERM_W-1:0];
         se_ff     <= pe[TERM_W-1:0];
         a_meas_ff <= q_data.measure;
         a_last_ff <= q_data.last;
      end
   end

   // running maximum, trace end and result hand-off
   always_comb begin
      take_a  = (state_ff == ST_RUN) && a_vld_ff;
      sum     = SQ_W'(su_ff) + SQ_W'(sn_ff) + SQ_W'(se_ff);
      max_nx  = max_ff;
      if (take_a && a_meas_ff && (!good_ff || sum > max_ff))
         max_nx = sum;
      good_nx = good_ff || (take_a && a_meas_ff);

      state_in        = state_ff;
      max_in          = max_nx;
      good_in         = good_nx;
      found_in        = found_ff;
      sq_req.start    = 1'b0;
      sq_req.radicand = max_nx;
      out_vld_in      = out_vld_ff && !rsp_ready;
      disp_in         = disp_ff;
      ofound_in       = ofound_ff;

      unique case (state_ff)
         ST_RUN: begin
            if (take_a && a_last_ff) begin
               sq_req.start = 1'b1;
               found_in     = good_nx;
               max_in       = '0;
               good_in      = 1'b0;
               state_in     = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (!sq_rsp.busy && (!out_vld_ff || rsp_ready)) begin
               out_vld_in = 1'b1;
               disp_in    = found_ff ? sq_rsp.root : '0;
               ofound_in  = found_ff;
               state_in   = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_RUN;
         a_vld_ff   <= 1'b0;
         max_ff     <= '0;
         good_ff    <= 1'b0;
         found_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         a_vld_ff   <= a_vld_in;
         max_ff     <= max_in;
         good_ff    <= good_in;
         found_ff   <= found_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      disp_ff   <= disp_in;
      ofound_ff <= ofound_in;
   end

   pvd_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sq_req),
      .rsp   (sq_rsp)
   );

endmodule

// File: rtl/peak_vector_displacement_unit.sv
// Peak vector displacement of a three-component position trace. Samples enter
// one per cycle while the queue is not full; the front captures the baseline at
// sample index csr ref_sample (or at the last sample if the trace ends first) and
// forms the differences, a four-item queue decouples it from the back, which
// squares, sums and keeps the running maximum at one item per cycle. The last
// sample of a trace starts a bit-serial square root of 31 root bits that holds
// the back until the result is handed off; during that time the front keeps
// accepting until the queue and the square stage are full. The result is held
// back by earlier queued items and by a stalled result port; it carries
// peak_found clear and a zero distance when the baseline was invalid or no
// valid sample was seen. ref_sample is to be written by the user only while the
// block is idle; the block itself does not enforce it.
// Files: pvd_pkg, pvd_front, pvd_queue, pvd_sqrt, pvd_back.
module peak_vector_displacement_unit #(
   parameter int MAX_SAMPLES = pvd_pkg::MAX_SAMPLES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [pvd_pkg::COUNT_W-1:0]      csr_write_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [pvd_pkg::POS_W-1:0] req_up_pos,
   input  logic signed [pvd_pkg::POS_W-1:0] req_north_pos,
   input  logic signed [pvd_pkg::POS_W-1:0] req_east_pos,
   input  logic                             req_sample_valid,
   input  logic                             req_sample_last,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pvd_pkg::DISP_W-1:0]       rsp_peak_disp,
   output logic                             rsp_peak_found
);
   import pvd_pkg::*;

   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   logic            push, pop, q_full, q_empty;
   work_type        push_data, pop_data;
   logic [CntW-1:0] q_count;

   assign q_full  = (q_count == CntW'(QUEUE_DEPTH));
   assign q_empty = (q_count == '0);

   // front end: baseline and classification
   pvd_front #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_up_pos       (req_up_pos),
      .req_north_pos    (req_north_pos),
      .req_east_pos     (req_east_pos),
      .req_sample_valid (req_sample_valid),
      .req_sample_last  (req_sample_last),
      .q_full           (q_full),
      .push             (push),
      .push_data        (push_data)
   );

   // decoupling queue
   pvd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .count     (q_count)
   );

   // back end: distance, maximum, square root
   pvd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_data         (pop_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_peak_disp  (rsp_peak_disp),
      .rsp_peak_found (rsp_peak_found)
   );

`ifndef SYNTH
   // queue occupancy stays within its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= CntW'(QUEUE_DEPTH))
      else $error("queue occupancy beyond depth");

   // a push without a pop grows the queue by one
   a_queue_grow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> q_count == $past(q_count) + 1'b1)
      else $error("queue count did not follow push");

   // a result without a peak carries a zero distance
   a_no_peak_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_peak_found |-> rsp_peak_disp == '0)
      else $error("nonzero distance without a peak");
`endif

endmodule

// File: bench/tb_peak_vector_displacement_unit.sv
// testbench for peak_vector_displacement_unit: directed traces, one long late-baseline trace
// and random traces, each checked against a local baseline and peak tracker
// depends on pvd_pkg and the peak_vector_displacement_unit rtl
module tb_peak_vector_displacement_unit;

   localparam int POS_W  = pvd_pkg::POS_W;
   localparam int SQ_W   = pvd_pkg::SQ_W;
   localparam int DISP_W = pvd_pkg::DISP_W;
   localparam int CNT_W  = pvd_pkg::COUNT_W;

   localparam int SAMPLE_BOUND  = pvd_pkg::MAX_SAMPLES_DEF;
   localparam int COUNT_SAT     = (SAMPLE_BOUND - 1 < 65535) ? SAMPLE_BOUND - 1 : 65535;
   localparam int SETTLE_CYCLES = 48;
   localparam int LONG_TRACE    = 200;
   localparam int LONG_REF      = 150;
   localparam int RANDOM_ITEMS  = 1300;
   localparam int MAX_REPORTS   = 10;

   typedef logic signed [POS_W-1:0] pos_type;

   typedef struct {
      logic [DISP_W-1:0] disp;
      logic              found;
   } peak_type;

   localparam pos_type POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam pos_type POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

   // block ports, all driven inputs known from time zero
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_write_en = 1'b0;
   logic [CNT_W-1:0] csr_write_data = '0;
   logic             req_valid = 1'b0;
   logic             req_ready;
   pos_type          req_up_pos = '0;
   pos_type          req_north_pos = '0;
   pos_type          req_east_pos = '0;
   logic             req_sample_valid = 1'b0;
   logic             req_sample_last = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b1;
   logic [DISP_W-1:0] rsp_peak_disp;
   logic             rsp_peak_found;

   peak_vector_displacement_unit #(
      .MAX_SAMPLES(SAMPLE_BOUND)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_up_pos(req_up_pos),
      .req_north_pos(req_north_pos),
      .req_east_pos(req_east_pos),
      .req_sample_valid(req_sample_valid),
      .req_sample_last(req_sample_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_peak_disp(rsp_peak_disp),
      .rsp_peak_found(rsp_peak_found)
   );

   // tracker state, mirrors the block between items
   logic [CNT_W-1:0] ref_index = '0;
   logic [CNT_W-1:0] trace_pos = '0;
   pos_type          anchor_up, anchor_north, anchor_east;
   logic             anchor_held = 1'b0;
   logic             anchor_ok = 1'b0;
   logic             seen_good = 1'b0;
   logic [SQ_W-1:0]  peak_sq = '0;

   peak_type pending_peaks[$];

   // idling control
   bit sender_gaps = 1'b0;
   bit receiver_stalls = 1'b0;
   int burst_left = 0;
   int ready_left = 0;
   int stall_left = 0;

   // run statistics
   int samples_sent = 0;
   int traces_sent = 0;
   int peaks_found = 0;
   int results_checked = 0;
   int ref_writes = 0;
   int mismatch_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #15_000_000;
      $display("timeout with %0d results outstanding", pending_peaks.size());
      $display("** peak_vector_displacement_unit: FAILED **");
      $finish;
   end

   // floor square root by setting result bits from the top down
   function automatic logic [DISP_W-1:0] floor_root(input logic [SQ_W-1:0] radicand);
      logic [63:0]       cand;
      logic [DISP_W-1:0] root;
      root = '0;
      for (int b = DISP_W - 1; b >= 0; b--) begin
         cand = 64'(root) | (64'd1 << b);
         if (cand * cand <= 64'(radicand))
            root = cand[DISP_W-1:0];
      end
      return root;
   endfunction

   // baseline capture, peak distance tracking and result on the last sample
   function automatic void track_sample(input pos_type up, input pos_type north,
                                        input pos_type east, input logic ok,
                                        input logic is_last);
      longint du, dn, de, sum;
      logic [SQ_W-1:0] sq_dist;
      peak_type peak;
      if (!anchor_held && (trace_pos == ref_index || is_last)) begin
         anchor_up    = up;
         anchor_north = north;
         anchor_east  = east;
         anchor_held  = 1'b1;
         anchor_ok    = ok;
      end
      if (anchor_held && anchor_ok && ok) begin
         du = longint'(up) - longint'(anchor_up);
         dn = longint'(north) - longint'(anchor_north);
         de = longint'(east) - longint'(anchor_east);
         sum = du * du + dn * dn + de * de;
         sq_dist = sum[SQ_W-1:0];
         if (!seen_good || sq_dist > peak_sq)
            peak_sq = sq_dist;
         seen_good = 1'b1;
      end
      if (trace_pos < COUNT_SAT)
         trace_pos++;
      if (is_last) begin
         peak.found = anchor_ok && seen_good;
         peak.disp  = peak.found ? floor_root(peak_sq) : '0;
         pending_peaks.push_back(peak);
         traces_sent++;
         if (peak.found)
            peaks_found++;
         trace_pos   = '0;
         anchor_up   = '0;
         anchor_north = '0;
         anchor_east = '0;
         anchor_held = 1'b0;
         anchor_ok   = 1'b0;
         seen_good   = 1'b0;
         peak_sq     = '0;
      end
   endfunction

   // result checking and receiver stall pattern
   always @(posedge clock) begin
      peak_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (pending_peaks.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result: disp %0d found %0b", rsp_peak_disp, rsp_peak_found);
         end else begin
            want = pending_peaks.pop_front();
            if (rsp_peak_disp !== want.disp || rsp_peak_found !== want.found) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("result %0d mismatch: disp %0d found %0b, expected disp %0d found %0b",
                           results_checked, rsp_peak_disp, rsp_peak_found, want.disp,
                           want.found);
            end
         end
      end
      if (ready_left == 0 && stall_left == 0) begin
         ready_left = $urandom_range(1, 12);
         stall_left = receiver_stalls ? $urandom_range(1, 6) : 0;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         ready_left--;
         rsp_ready <= 1'b1;
      end
   end

   // send one sample, waiting for acceptance; valid stays high for the next item
   task automatic send_sample(input pos_type up, input pos_type north, input pos_type east,
                              input logic ok, input logic is_last);
      int gap;
      if (sender_gaps && burst_left == 0) begin
         gap = $urandom_range(0, 4);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_up_pos       <= up;
      req_north_pos    <= north;
      req_east_pos     <= east;
      req_sample_valid <= ok;
      req_sample_last  <= is_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (burst_left > 0)
         burst_left--;
      samples_sent++;
      track_sample(up, north, east, ok, is_last);
   endtask

   // drain all outstanding results and let the back end go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_peaks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ref(input logic [CNT_W-1:0] value);
      settle();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      ref_index = value;
      ref_writes++;
   endtask

   // one position component: full range, extremes or near the trace centre
   function automatic pos_type pick_component(input pos_type centre);
      case ($urandom_range(0, 5))
         0: return pos_type'($urandom);
         1: return POS_MIN;
         2: return POS_MAX;
         default: return centre + pos_type'($urandom_range(0, 4000)) - pos_type'(2000);
      endcase
   endfunction

   task automatic send_random_sample(input pos_type centre, input logic is_last);
      send_sample(pick_component(centre), pick_component(centre), pick_component(centre),
                  $urandom_range(0, 9) != 0, is_last);
   endtask

   // baseline at index zero: extremes, single-sample and invalid baseline traces
   task automatic test_baseline_at_start();
      send_sample(POS_MIN, POS_MIN, POS_MIN, 1'b1, 1'b0);
      send_sample(POS_MAX, POS_MAX, POS_MAX, 1'b1, 1'b0);
      send_sample(POS_MAX, POS_MIN, '0, 1'b0, 1'b0);
      send_sample('0, '0, '0, 1'b1, 1'b1);
      send_sample(pos_type'(5), pos_type'(-7), pos_type'(9), 1'b1, 1'b1);
      send_sample(POS_MAX, POS_MAX, POS_MAX, 1'b0, 1'b1);
      // invalid baseline, nothing measured
      send_sample(pos_type'(1), pos_type'(2), pos_type'(3), 1'b0, 1'b0);
      send_sample(POS_MAX, POS_MAX, POS_MAX, 1'b1, 1'b0);
      send_sample(POS_MIN, '0, '0, 1'b1, 1'b1);
      // valid baseline, everything after it invalid
      send_sample(pos_type'(100), pos_type'(100), pos_type'(100), 1'b1, 1'b0);
      send_sample(POS_MIN, POS_MIN, POS_MIN, 1'b0, 1'b0);
      send_sample('0, '0, '0, 1'b0, 1'b1);
   endtask

   // baseline later in the trace, and traces that end before the baseline index
   task automatic test_baseline_offset();
      write_ref(16'd3);
      repeat (3) send_sample(POS_MAX, POS_MIN, POS_MAX, 1'b1, 1'b0);
      send_sample(pos_type'(10), pos_type'(20), pos_type'(30), 1'b1, 1'b0);
      send_sample(pos_type'(13), pos_type'(24), pos_type'(30), 1'b1, 1'b0);
      send_sample(pos_type'(10), pos_type'(20), pos_type'(30), 1'b1, 1'b1);
      send_sample(pos_type'(7), pos_type'(7), pos_type'(7), 1'b1, 1'b0);
      send_sample(pos_type'(1), pos_type'(1), pos_type'(1), 1'b1, 1'b1);
      write_ref(16'hFFFF);
      send_sample(POS_MIN, POS_MIN, POS_MIN, 1'b1, 1'b0);
      send_sample('0, '0, '0, 1'b1, 1'b1);
   endtask

   // one long back-to-back trace with the baseline well into it
   task automatic test_long_trace();
      pos_type centre;
      write_ref(CNT_W'(LONG_REF));
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      centre = pos_type'($urandom);
      for (int i = 0; i < LONG_TRACE; i++)
         send_random_sample(centre, i == LONG_TRACE - 1);
   endtask

   // phases of random traces under changing baseline index and idling
   task automatic test_random_traces();
      int sent;
      int phase_items;
      int trace_len;
      pos_type centre;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0: write_ref('0);
            1: write_ref(16'hFFFF);
            2: write_ref(CNT_W'($urandom));
            default: write_ref(CNT_W'($urandom_range(0, 40)));
         endcase
         sender_gaps = $urandom_range(0, 3) != 0;
         receiver_stalls = $urandom_range(0, 3) != 0;
         phase_items = 0;
         while (phase_items < 125) begin
            trace_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2)
                                                    : $urandom_range(1, 48);
            centre = pos_type'($urandom);
            for (int i = 0; i < trace_len; i++)
               send_random_sample(centre, i == trace_len - 1);
            phase_items += trace_len;
         end
         sent += phase_items;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_baseline_at_start();
      test_baseline_offset();
      test_long_trace();
      test_random_traces();
      settle();
      $display("run covered %0d samples in %0d traces, %0d with a peak, %0d results checked",
               samples_sent, traces_sent, peaks_found, results_checked);
      $display("baseline index written %0d times, %0d mismatches", ref_writes, mismatch_count);
      if (mismatch_count == 0) begin
         $display("** peak_vector_displacement_unit: PASSED **");
      end else begin
         $display("** peak_vector_displacement_unit: FAILED **");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/pvd_pkg.sv
rtl/pvd_front.sv
rtl/pvd_queue.sv
rtl/pvd_sqrt.sv
rtl/pvd_back.sv
rtl/peak_vector_displacement_unit.sv
bench/tb_peak_vector_displacement_unit.sv
